[sv/id_number_check_digit_validator_defines.svh]
// assertion macros for the identity number check digit validator
// used by the checker module only; no other dependencies
`ifndef ID_NUMBER_CHECK_DIGIT_VALIDATOR_DEFINES_SVH
`define ID_NUMBER_CHECK_DIGIT_VALIDATOR_DEFINES_SVH

// property checked on every clock edge outside of reset
`define IDNV_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define IDNV_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[sv/idnv_pkg.sv]
// shared types, constants and table functions of the check digit validator
// no dependencies
package idnv_pkg;

    localparam logic [1:0] KIND_CPF  = 2'd0;
    localparam logic [1:0] KIND_CNPJ = 2'd1;
    localparam logic [1:0] KIND_RG   = 2'd2;

    localparam logic [7:0] CHAR_ZERO = 8'd48;
    localparam logic [7:0] CHAR_NINE = 8'd57;
    localparam logic [4:0] POS_MAX   = 5'd31;

    // digit positions of each format, punctuation cleared
    localparam logic [31:0] MASK_CPF  = 32'h0000_3777;
    localparam logic [31:0] MASK_CNPJ = 32'h0003_7BBB;
    localparam logic [31:0] MASK_RG   = 32'h0000_0BBB;

    localparam logic [3:0] WA_CPF  [16] = '{1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 0, 0, 0, 0, 0, 0};
    localparam logic [3:0] WA_CNPJ [16] = '{5, 4, 3, 2, 9, 8, 7, 6, 5, 4, 3, 2, 0, 0, 0, 0};
    localparam logic [3:0] WA_RG   [16] = '{9, 8, 7, 6, 5, 4, 3, 2, 0, 0, 0, 0, 0, 0, 0, 0};
    localparam logic [3:0] WB_CPF  [16] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 0, 0, 0, 0, 0, 0};
    localparam logic [3:0] WB_CNPJ [16] = '{6, 5, 4, 3, 2, 9, 8, 7, 6, 5, 4, 3, 2, 0, 0, 0};
    localparam logic [3:0] RM_CPF  [16] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 10, 1, 0, 0, 0, 0, 0};
    localparam logic [3:0] RM_CNPJ [16] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 10, 1, 0, 0};
    localparam logic [3:0] RM_RG   [16] = '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0};

    typedef struct packed {
        logic [7:0] doc_char;
        logic       last;
    } t_in_req;

    typedef struct packed {
        logic       valid_res;
        logic       length_ok;
        logic [6:0] check_value;
    } t_out_res;

    // character held in the input stage, with the format it arrived under
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] doc_char;
        logic       last;
    } t_stage;

    // per-number totals handed to the result stage on the last character
    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] first_res;
        logic [3:0] second_res;
        logic [6:0] received;
        logic       bad;
        logic [4:0] count;
    } t_fin;

    function automatic logic digit_pos(input logic [1:0] kind, input logic [4:0] pos);
        logic [31:0] mask;
        case (kind)
            KIND_CPF:  mask = MASK_CPF;
            KIND_CNPJ: mask = MASK_CNPJ;
            KIND_RG:   mask = MASK_RG;
            default:   mask = '0;
        endcase
        return mask[pos];
    endfunction

    function automatic logic [3:0] weight_a(input logic [1:0] kind, input logic [3:0] idx);
        logic [3:0] w;
        case (kind)
            KIND_CPF:  w = WA_CPF[idx];
            KIND_CNPJ: w = WA_CNPJ[idx];
            KIND_RG:   w = WA_RG[idx];
            default:   w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] weight_b(input logic [1:0] kind, input logic [3:0] idx);
        logic [3:0] w;
        case (kind)
            KIND_CPF:  w = WB_CPF[idx];
            KIND_CNPJ: w = WB_CNPJ[idx];
            default:   w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [3:0] recv_mul(input logic [1:0] kind, input logic [3:0] idx);
        logic [3:0] w;
        case (kind)
            KIND_CPF:  w = RM_CPF[idx];
            KIND_CNPJ: w = RM_CNPJ[idx];
            KIND_RG:   w = RM_RG[idx];
            default:   w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [4:0] fmt_len(input logic [1:0] kind);
        logic [4:0] len;
        case (kind)
            KIND_CPF:  len = 5'd14;
            KIND_CNPJ: len = 5'd18;
            KIND_RG:   len = 5'd12;
            default:   len = 5'd0;
        endcase
        return len;
    endfunction

    // x mod 11 for x below 128, by reciprocal multiply (187 / 2048)
    function automatic logic [3:0] mod11(input logic [6:0] x);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = {8'd0, x} * 15'd187;
        q    = prod[14:11];
        r    = x - ({3'd0, q} * 7'd11);
        return r[3:0];
    endfunction

endpackage

[sv/idnv_accum.sv]
// per-number accumulator: position counters, weighted sums kept mod 11,
// received check digits and bad-digit flag; uses idnv_pkg
module idnv_accum (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  idnv_pkg::t_stage i_item,
    output idnv_pkg::t_fin  o_fin
);
    import idnv_pkg::*;

    logic [4:0] r_pos;
    logic [3:0] r_idx;
    logic [3:0] r_first;
    logic [3:0] r_second;
    logic [6:0] r_recv;
    logic       r_bad;

    logic [4:0] n_pos;
    logic [3:0] n_idx;
    logic [3:0] n_first;
    logic [3:0] n_second;
    logic [6:0] n_recv;
    logic       n_bad;

    logic       is_dig;
    logic       is_num;
    logic [7:0] diff;
    logic [3:0] d;
    logic [7:0] pa;
    logic [7:0] pb;
    logic [7:0] pr;

    always_comb begin
        is_dig = digit_pos(i_item.kind, r_pos);
        is_num = (i_item.doc_char >= CHAR_ZERO) && (i_item.doc_char <= CHAR_NINE);
        diff   = i_item.doc_char - CHAR_ZERO;
        d      = is_num ? diff[3:0] : 4'd0;
        pa     = {4'd0, d} * {4'd0, weight_a(i_item.kind, r_idx)};
        pb     = {4'd0, d} * {4'd0, weight_b(i_item.kind, r_idx)};
        pr     = {4'd0, d} * {4'd0, recv_mul(i_item.kind, r_idx)};

        n_pos    = r_pos;
        n_idx    = r_idx;
        n_first  = r_first;
        n_second = r_second;
        n_recv   = r_recv;
        n_bad    = r_bad;
        if (is_dig) begin
            n_first  = mod11({3'd0, r_first} + pa[6:0]);
            n_second = mod11({3'd0, r_second} + pb[6:0]);
            n_recv   = r_recv + pr[6:0];
            n_bad    = r_bad | ~is_num;
            n_idx    = r_idx + 4'd1;
        end
        if (r_pos != POS_MAX) begin
            n_pos = r_pos + 5'd1;
        end

        o_fin.kind       = i_item.kind;
        o_fin.first_res  = n_first;
        o_fin.second_res = n_second;
        o_fin.received   = n_recv;
        o_fin.bad        = n_bad;
        o_fin.count      = n_pos;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_item.last)) begin
            r_pos    <= '0;
            r_idx    <= '0;
            r_first  <= '0;
            r_second <= '0;
            r_recv   <= '0;
            r_bad    <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_idx    <= n_idx;
            r_first  <= n_first;
            r_second <= n_second;
            r_recv   <= n_recv;
            r_bad    <= n_bad;
        end
    end

endmodule

[sv/idnv_result.sv]
// check value formation and result register with valid/ready output
// uses idnv_pkg
module idnv_result (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  idnv_pkg::t_fin    i_fin,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output idnv_pkg::t_out_res o_out_res,
    output logic              o_free
);
    import idnv_pkg::*;

    logic     r_valid;
    t_out_res r_res;
    t_out_res n_res;

    logic [3:0] d1;
    logic [3:0] d2;
    logic [6:0] chk;
    logic       len_ok;

    always_comb begin
        d1  = 4'd0;
        d2  = 4'd0;
        chk = 7'd0;
        case (i_fin.kind)
            KIND_CPF: begin
                d1  = (i_fin.first_res == 4'd10) ? 4'd0 : i_fin.first_res;
                d2  = (i_fin.second_res == 4'd10) ? 4'd0 : i_fin.second_res;
                chk = ({3'd0, d1} * 7'd10) + {3'd0, d2};
            end
            KIND_CNPJ: begin
                d1  = (i_fin.first_res < 4'd2) ? 4'd0 : 4'd11 - i_fin.first_res;
                d2  = (i_fin.second_res < 4'd2) ? 4'd0 : 4'd11 - i_fin.second_res;
                chk = ({3'd0, d1} * 7'd10) + {3'd0, d2};
            end
            KIND_RG: begin
                chk = {3'd0, i_fin.first_res};
            end
            default: begin
                chk = 7'd0;
            end
        endcase
        len_ok            = (i_fin.count == fmt_len(i_fin.kind));
        n_res.check_value = chk;
        n_res.length_ok   = len_ok;
        n_res.valid_res   = len_ok && !i_fin.bad && (chk == i_fin.received);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_take) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
        if (i_take) begin
            r_res <= n_res;
        end
    end

    assign o_free      = !r_valid || i_out_ready;
    assign o_out_valid = r_valid;
    assign o_out_res   = r_res;

endmodule

[sv/id_number_check_digit_validator.sv]
// top level of the identity number check digit validator (CPF, CNPJ, RG)
// depends on idnv_pkg, idnv_accum, idnv_result
//
// usage:
//   - the user sets the format register (0 CPF, 1 CNPJ, 2 RG) via i_cfg_wr_en /
//     i_cfg_wr_data only while no number is in flight, not enforced by the block
//   - the input channel (i_in_valid / o_in_ready) carries one request per
//     character of the formatted number; last marks the final character
//   - the output channel (o_out_valid / i_out_ready) carries one result per
//     number, produced only for the request that has last set
//   - a last character's result passes two register stages (input register,
//     result register) and waits in the input register while the slot is full
//   - throughput: one character per cycle unless a last character waits for the
//     result slot, set by the single accumulate step between the two registers;
//     sums are kept mod 11 by reciprocal multiply; the end check maps digits
//   - when the receiver stalls, the result waits in its register; characters
//     of the next number keep flowing until a second last character reaches
//     the input register, which then holds and drops o_in_ready
//   - reset (i_rst_n low, synchronous) empties both registers, clears the
//     sums and counters and selects CPF
module id_number_check_digit_validator (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [1:0]          i_cfg_wr_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  idnv_pkg::t_in_req   i_in_req,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output idnv_pkg::t_out_res  o_out_res
);
    import idnv_pkg::*;

    // format register
    logic [1:0] r_doc_kind;

    // input register stage
    logic   r_s1_valid;
    t_stage r_s1;

    logic   s1_fire;
    logic   in_fire;
    logic   out_free;
    t_fin   fin;

    // a plain character always moves on; a last one needs the result slot
    assign s1_fire    = r_s1_valid && (!r_s1.last || out_free);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_doc_kind <= KIND_CPF;
        end else if (i_cfg_wr_en) begin
            r_doc_kind <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
        // format is captured with each character
        if (in_fire) begin
            r_s1.kind     <= r_doc_kind;
            r_s1.doc_char <= i_in_req.doc_char;
            r_s1.last     <= i_in_req.last;
        end
    end

    // running sums, counters and received check digits
    idnv_accum u_accum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (s1_fire),
        .i_item  (r_s1),
        .o_fin   (fin)
    );

    // check digit rules, compare, result register
    idnv_result u_result (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (s1_fire && r_s1.last),
        .i_fin       (fin),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_res   (o_out_res),
        .o_free      (out_free)
    );

endmodule

[sv/idnv_checker.sv]
// port-level assertions for the check digit validator, bound to the top level
// depends on idnv_pkg and id_number_check_digit_validator_defines.svh
`include "id_number_check_digit_validator_defines.svh"

module idnv_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input idnv_pkg::t_out_res  o_out_res
);
    import idnv_pkg::*;

    // no result shows in the cycle after reset
    `IDNV_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_out_valid, "result valid after reset")

    // with the result slot empty the input side never stalls
    `IDNV_ASSERT(a_ready_empty, !o_out_valid |-> o_in_ready, "input stalled with empty output")

    // a passing number always has the right length
    `IDNV_ASSERT(a_valid_len, (o_out_valid && o_out_res.valid_res) |-> o_out_res.length_ok,
                 "valid without length")

    // a stalled result holds
    `IDNV_ASSERT(a_hold, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_res)),
                 "stalled result changed")

endmodule

bind id_number_check_digit_validator idnv_checker u_idnv_checker (.*);
